// ----- hdl/hash_table_insert_search_core_defines.svh -----
// Assertion macros used by the hash table RTL.
`ifndef HASH_TABLE_INSERT_SEARCH_CORE_DEFINES_SVH
`define HASH_TABLE_INSERT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/htis_pkg.sv -----
// Shared widths, opcodes and status codes of the hash table core.
package htis_pkg;

	localparam int KEY_W    = 31;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;

	// Home slot is computed one 4-bit digit per cycle over the zero-padded key.
	localparam int DIGIT_W    = 4;
	localparam int KEY_DIGITS = 8;
	localparam int DCNT_W     = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

endpackage

// ----- hdl/htis_if.sv -----
// Request and response channel interfaces of the hash table core.
interface htis_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [htis_pkg::KEY_W-1:0] key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink (input valid, input opcode, input key, output ready);
endinterface

interface htis_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [htis_pkg::STATUS_W-1:0] status;
	logic [htis_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink (input valid, input status, input slot, output ready);
endinterface

// ----- hdl/htis_mod.sv -----
// Digit-serial key modulo TABLE_SIZE: one 4-bit digit per cycle, MSB first.
module htis_mod #(
	parameter int TABLE_SIZE = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [htis_pkg::KEY_W-1:0]  key,
	output logic                        done,
	output logic [$clog2(TABLE_SIZE)-1:0] rem
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int T_W   = IDX_W + htis_pkg::DIGIT_W;
	localparam int SH_W  = htis_pkg::DIGIT_W * htis_pkg::KEY_DIGITS;
	localparam logic [T_W-1:0] MOD_N = T_W'(TABLE_SIZE);
	localparam logic [htis_pkg::DCNT_W-1:0] LAST_DIGIT =
		htis_pkg::DCNT_W'(htis_pkg::KEY_DIGITS - 1);

	logic [SH_W-1:0]                 sh_q;
	logic [IDX_W-1:0]                rem_q;
	logic [htis_pkg::DCNT_W-1:0]     cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [T_W-1:0]                  t_acc;
	logic [T_W-1:0]                  t_sub;

	// Shift the digit in, then reduce with a four-step restoring subtract.
	always_comb begin
		t_acc = {rem_q, sh_q[SH_W-1 -: htis_pkg::DIGIT_W]};
		for (int j = htis_pkg::DIGIT_W - 1; j >= 0; j--) begin
			t_sub = MOD_N << j;
			if (t_acc >= t_sub) begin
				t_acc = t_acc - t_sub;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_DIGIT) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= SH_W'(key);
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << htis_pkg::DIGIT_W;
			rem_q <= t_acc[IDX_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/hash_table_insert_search_core.sv -----
// Top level of the open-addressing hash table with insert and search.
//
//  channel | dir | fields            | handshake
//  req     | in  | opcode, key       | valid/ready, taken when both high
//  rsp     | out | status, slot      | valid/ready, held in an output register
//
// For an item with a nonzero key the slot scan (one table read per cycle) runs beside the
// digit-serial modulo, and the result is decided once both are done.
// A zero key skips the scan and goes straight to the decision. req.ready is high only while idle.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset clears all slot valid bits at once; an invalid slot reads as empty.
`include "hash_table_insert_search_core_defines.svh"

module hash_table_insert_search_core #(
	parameter int TABLE_SIZE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	htis_req_if.sink    req,
	htis_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_SIZE);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	state_t state_q;

	logic                              op_q;
	logic [htis_pkg::KEY_W-1:0]        key_q;
	logic                              inv_q;
	logic [CNT_W-1:0]                  scan_q;
	logic [TABLE_SIZE-1:0]             hit_vec_q;
	logic                              any_q;
	logic [IDX_W-1:0]                  first_q;

	logic [htis_pkg::KEY_W-1:0]        mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0]             valid_q;

	logic                              rd_act_s1;
	logic [IDX_W-1:0]                  rd_idx_s1;
	logic [htis_pkg::KEY_W-1:0]        rd_key_s1;
	logic                              rd_vld_s1;

	logic                              rsp_valid_q;
	logic [htis_pkg::STATUS_W-1:0]     rsp_status_q;
	logic [htis_pkg::SLOT_W-1:0]       rsp_slot_q;

	logic                              accept;
	logic                              key_zero;
	logic                              rd_issue;
	logic [htis_pkg::KEY_W-1:0]        entry;
	logic                              hit;
	logic                              mod_done;
	logic [IDX_W-1:0]                  home;
	logic                              load;
	logic [htis_pkg::STATUS_W-1:0]     res_status;
	logic [IDX_W-1:0]                  res_idx;
	logic                              wr_en;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign key_zero  = (req.key == '0);
	assign rd_issue  = (state_q == S_SCAN) && (scan_q != SCAN_END);

	htis_mod #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !key_zero),
		.key    (req.key),
		.done   (mod_done),
		.rem    (home)
	);

	// Empty slots match an insert, equal keys match a search.
	assign entry = rd_vld_s1 ? rd_key_s1 : '0;
	assign hit   = (op_q == htis_pkg::OP_INSERT) ? (entry == '0) : (entry == key_q);

	always_comb begin
		res_status = htis_pkg::ST_OK;
		res_idx    = '0;
		if (inv_q) begin
			res_status = htis_pkg::ST_INVALID;
		end else if (hit_vec_q[home]) begin
			res_idx = home;
		end else if (any_q) begin
			res_idx = first_q;
		end else if (op_q == htis_pkg::OP_INSERT) begin
			res_status = htis_pkg::ST_FULL;
		end else begin
			res_status = htis_pkg::ST_NOT_FOUND;
		end
	end

	assign load  = (state_q == S_DECIDE) && (!rsp_valid_q || rsp.ready);
	assign wr_en = load && !inv_q && (op_q == htis_pkg::OP_INSERT) &&
		(res_status == htis_pkg::ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_q    <= '0;
			rd_act_s1 <= 1'b0;
			hit_vec_q <= '0;
			any_q     <= 1'b0;
		end else begin
			rd_act_s1 <= rd_issue;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q    <= '0;
						hit_vec_q <= '0;
						any_q     <= 1'b0;
						state_q   <= key_zero ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_act_s1 && hit) begin
						hit_vec_q[rd_idx_s1] <= 1'b1;
						any_q                <= 1'b1;
					end
					if (!rd_issue && !rd_act_s1 && mod_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Keep the lowest hit of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			inv_q <= key_zero;
		end
		if (rd_act_s1 && hit && !any_q) begin
			first_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_key_s1 <= mem[scan_q[IDX_W-1:0]];
			rd_vld_s1 <= valid_q[scan_q[IDX_W-1:0]];
			rd_idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (wr_en) begin
			mem[res_idx] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[res_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status_q <= res_status;
			rsp_slot_q   <= htis_pkg::SLOT_W'(res_idx);
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.slot   = rsp_slot_q;

	`HTIS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !req.ready,
		"accepted item did not drop ready")
	`HTIS_ASSERT_NOW(a_home_ready, clk, arst_n, (state_q == S_DECIDE) && !inv_q, mod_done,
		"decision taken before home slot was known")
	`HTIS_ASSERT_NOW(a_write_empty, clk, arst_n, wr_en, !valid_q[res_idx],
		"insert overwrote an occupied slot")
	`HTIS_ASSERT_NOW(a_no_read_on_write, clk, arst_n, wr_en, !rd_issue && !rd_act_s1,
		"table write overlapped the scan")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of the hash table insert and search core.
module testbench;

	localparam int TABLE_SIZE  = 8;
	localparam int NUM_ROWS    = 21;
	localparam int NUM_RANDOM  = 1080;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 24;

	typedef struct packed {
		logic [htis_pkg::STATUS_W-1:0] status;
		logic [htis_pkg::SLOT_W-1:0]   slot;
	} reply_t;

	typedef struct packed {
		logic                          opcode;
		logic [htis_pkg::KEY_W-1:0]    key;
		logic                          fixed;
		logic [htis_pkg::STATUS_W-1:0] status;
		logic [htis_pkg::SLOT_W-1:0]   slot;
	} stim_row_t;

	logic clk;
	logic arst_n;

	htis_req_if req_ch();
	htis_rsp_if rsp_ch();

	hash_table_insert_search_core #(.TABLE_SIZE(TABLE_SIZE)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [htis_pkg::KEY_W-1:0] shadow_keys [TABLE_SIZE];
	reply_t                     due_replies [$];
	int                         errors       = 0;
	int                         items_sent   = 0;
	int                         quiet_cycles = 0;
	logic                       steady;

	// Rows with fixed set carry a typed reply; the others take the shadow table's answer.
	stim_row_t lookup_rows [NUM_ROWS] = '{
		'{htis_pkg::OP_SEARCH, 31'd5,        1'b1, htis_pkg::ST_NOT_FOUND, 6'd0},
		'{htis_pkg::OP_INSERT, 31'd0,        1'b1, htis_pkg::ST_INVALID,   6'd0},
		'{htis_pkg::OP_SEARCH, 31'd0,        1'b1, htis_pkg::ST_INVALID,   6'd0},
		'{htis_pkg::OP_INSERT, 31'h7FFFFFFF, 1'b1, htis_pkg::ST_OK,        6'd7},
		'{htis_pkg::OP_SEARCH, 31'h7FFFFFFF, 1'b1, htis_pkg::ST_OK,        6'd7},
		'{htis_pkg::OP_INSERT, 31'd8,        1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'd16,       1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'd16,       1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_SEARCH, 31'd16,       1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'd9,        1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'd12,       1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'h40000005, 1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_SEARCH, 31'd9,        1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'h7FFFFFFE, 1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'd1,        1'b1, htis_pkg::ST_FULL,      6'd0},
		'{htis_pkg::OP_INSERT, 31'h7FFFFFFF, 1'b1, htis_pkg::ST_FULL,      6'd0},
		'{htis_pkg::OP_SEARCH, 31'h7FFFFFF7, 1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_SEARCH, 31'd8,        1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_SEARCH, 31'd12,       1'b0, htis_pkg::ST_OK,        6'd0},
		'{htis_pkg::OP_INSERT, 31'd0,        1'b1, htis_pkg::ST_INVALID,   6'd0},
		'{htis_pkg::OP_SEARCH, 31'h40000005, 1'b0, htis_pkg::ST_OK,        6'd0}
	};

	// Insert or search against the shadow table and return the reply it calls for.
	function automatic reply_t probe_table(input logic op,
			input logic [htis_pkg::KEY_W-1:0] k);
		reply_t r;
		int     home;
		int     i;
		r.status = htis_pkg::ST_OK;
		r.slot   = '0;
		if (k == '0) begin
			r.status = htis_pkg::ST_INVALID;
			return r;
		end
		home = k % TABLE_SIZE;
		if (op == htis_pkg::OP_INSERT) begin
			if (shadow_keys[home] == '0) begin
				shadow_keys[home] = k;
				r.slot = htis_pkg::SLOT_W'(home);
				return r;
			end
			for (i = 0; i < TABLE_SIZE; i++) begin
				if (shadow_keys[i] == '0) begin
					shadow_keys[i] = k;
					r.slot = htis_pkg::SLOT_W'(i);
					return r;
				end
			end
			r.status = htis_pkg::ST_FULL;
			return r;
		end
		if (shadow_keys[home] == k) begin
			r.slot = htis_pkg::SLOT_W'(home);
			return r;
		end
		for (i = 0; i < TABLE_SIZE; i++) begin
			if (shadow_keys[i] == k) begin
				r.slot = htis_pkg::SLOT_W'(i);
				return r;
			end
		end
		r.status = htis_pkg::ST_NOT_FOUND;
		return r;
	endfunction

	// Present one item from a falling edge; return at the falling edge after it is taken.
	task automatic offer_item(input logic op, input logic [htis_pkg::KEY_W-1:0] k,
			input logic fixed, input reply_t typed);
		reply_t predicted;
		while (!steady && $urandom_range(99) < 35) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.key    <= k;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = probe_table(op, k);
		due_replies.push_back(fixed ? typed : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold off new items until every reply is back.
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (due_replies.size() != 0)
			@(negedge clk);
	endtask

	assign steady = (items_sent >= 400) && (items_sent < 650);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk)
		rsp_ch.ready <= steady || ($urandom_range(99) >= 35);

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_replies.size() == 0) begin
					$display("%0t: unexpected reply expected none got status %0d slot %0d",
						$time, rsp_ch.status, rsp_ch.slot);
					errors++;
				end else begin
					want = due_replies.pop_front();
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status mismatch expected %0d got %0d", $time,
							want.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.slot !== want.slot) begin
						$display("%0t: slot mismatch expected %0d got %0d", $time,
							want.slot, rsp_ch.slot);
						errors++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("hash_table_insert_search_core regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [htis_pkg::KEY_W-1:0] k;
		logic                       op;
		int                         pick;
		reply_t                     typed;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.opcode = htis_pkg::OP_INSERT;
		req_ch.key    = '0;
		for (int i = 0; i < TABLE_SIZE; i++)
			shadow_keys[i] = '0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (lookup_rows[r]) begin
			typed.status = lookup_rows[r].status;
			typed.slot   = lookup_rows[r].slot;
			offer_item(lookup_rows[r].opcode, lookup_rows[r].key, lookup_rows[r].fixed, typed);
		end
		drain_replies();

		typed = '0;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			pick = $urandom_range(99);
			op   = htis_pkg::OP_SEARCH;
			if (pick < 40) begin
				k = shadow_keys[$urandom_range(TABLE_SIZE - 1)];
			end else if (pick < 60) begin
				k = htis_pkg::KEY_W'($urandom());
			end else if (pick < 75) begin
				// near miss: one key bit flipped from a stored key
				k = shadow_keys[$urandom_range(TABLE_SIZE - 1)];
				k[$urandom_range(htis_pkg::KEY_W - 1)] ^= 1'b1;
			end else if (pick < 95) begin
				op = htis_pkg::OP_INSERT;
				k  = ($urandom_range(1) == 0) ? htis_pkg::KEY_W'($urandom())
					: shadow_keys[$urandom_range(TABLE_SIZE - 1)];
			end else begin
				op = $urandom_range(1) ? htis_pkg::OP_SEARCH : htis_pkg::OP_INSERT;
				k  = '0;
			end
			offer_item(op, k, 1'b0, typed);
			if (n % 250 == 249)
				drain_replies();
		end

		drain_replies();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("hash_table_insert_search_core regression: pass");
		else
			$display("hash_table_insert_search_core regression: fail");
		$finish;
	end

endmodule
